### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WTQ_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtq assertion failed");

// next-cycle implication, disabled while in reset
`define WTQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtq assertion failed");

`endif

### design/wtq_pkg.sv
// types and constants of the sorted wake-time queue
package wtq_pkg;

  // field widths of the request and response channels
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned FIELD_ID_W   = 16;
  localparam int unsigned FIELD_TIME_W = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OCC_W     = 6;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REPLACE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAST     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTDUE   = 3'd5;

  // operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_RENAME
  } cell_op_e;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_op_e op;
    logic     valid;     // cell lies below the fill count
    logic     shift_en;  // take the right neighbour on a shift
    logic     left_le;   // left neighbour wakes at or before the new time
  } cell_ctl_t;

  // per-cell compare results
  typedef struct packed {
    logic id_hit;
    logic nid_hit;
    logic time_le;
  } cell_flags_t;

endpackage

### design/wtq_req_if.sv
// request channel of the wake-time queue
interface wtq_req_if import wtq_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [FIELD_ID_W-1:0]   entry_id;
  logic [FIELD_ID_W-1:0]   new_id;
  logic [FIELD_TIME_W-1:0] wake_at;

  modport source (output valid, action, entry_id, new_id, wake_at, input ready);
  modport sink   (input valid, action, entry_id, new_id, wake_at, output ready);
endinterface

### design/wtq_rsp_if.sv
// response channel of the wake-time queue
interface wtq_rsp_if import wtq_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [FIELD_ID_W-1:0]   result_id;
  logic [FIELD_TIME_W-1:0] result_time;
  logic [STATUS_W-1:0]     status;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, result_id, result_time, status, occupancy, input ready);
  modport sink   (input valid, result_id, result_time, status, occupancy, output ready);
endinterface

### design/wtq_cell.sv
// one queue cell: holds an entry, compares it, hands it to a neighbour
module wtq_cell import wtq_pkg::*; #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  cell_ctl_t            ctl_i,
  input  logic [ID_BITS-1:0]   req_id_i,
  input  logic [ID_BITS-1:0]   req_nid_i,
  input  logic [TIME_BITS-1:0] req_time_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic [TIME_BITS-1:0] left_time_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic [TIME_BITS-1:0] right_time_i,
  output logic [ID_BITS-1:0]   id_o,
  output logic [TIME_BITS-1:0] time_o,
  output cell_flags_t          flags_o
);

  logic [ID_BITS-1:0]   id_q, id_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  cell_flags_t          flags;

  // compare the held entry against the request
  always_comb begin
    flags.id_hit  = ctl_i.valid && (id_q == req_id_i);
    flags.nid_hit = ctl_i.valid && (id_q == req_nid_i);
    flags.time_le = ctl_i.valid && (time_q <= req_time_i);
  end

  // next entry: keep, take the new one, or take a neighbour's
  always_comb begin
    id_d   = id_q;
    time_d = time_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!flags.time_le) begin
          if (ctl_i.left_le) begin
            id_d   = req_id_i;
            time_d = req_time_i;
          end else begin
            id_d   = left_id_i;
            time_d = left_time_i;
          end
        end
      end
      CELL_SHIFT: begin
        if (ctl_i.shift_en) begin
          id_d   = right_id_i;
          time_d = right_time_i;
        end
      end
      CELL_RENAME: begin
        if (flags.id_hit) begin
          id_d = req_nid_i;
        end
      end
    endcase
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    time_q <= time_d;
  end

  assign id_o    = id_q;
  assign time_o  = time_q;
  assign flags_o = flags;

endmodule

### design/sorted_wake_time_queue.sv
// Sorted wake-time queue: a row of cells kept in wake-time order, plus a time counter.
// The request is captured, then its result is registered in the response register.
// One request at a time: a capture step, then one compare-and-shift step over the whole cell
// row; a stalled response holds the row in its second step.
// Reset: fill count and current time clear at once; cell contents are left as they are,
// no clearing pass.
module sorted_wake_time_queue import wtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wtq_req_if.sink       req_i,
  wtq_rsp_if.source     rsp_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [TIME_BITS-1:0] now_q, now_d;

  // captured request
  logic [ACTION_W-1:0]  act_q;
  logic [ID_BITS-1:0]   id_q, nid_q;
  logic [TIME_BITS-1:0] wt_q;

  // response register
  logic                    rsp_valid_q;
  logic [FIELD_ID_W-1:0]   rsp_id_q;
  logic [FIELD_TIME_W-1:0] rsp_time_q;
  logic [STATUS_W-1:0]     rsp_status_q;
  logic [OCC_W-1:0]        rsp_occ_q;

  // cell row wiring
  logic [ID_BITS-1:0]   cell_id   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] cell_time [QUEUE_DEPTH];
  cell_flags_t          flags     [QUEUE_DEPTH];
  cell_ctl_t            ctl       [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] id_hit, nid_hit, time_le, hit_upto;

  logic                 accept, out_free, fire;
  logic                 any_hit, any_nid_hit;
  logic [TIME_BITS-1:0] sel_time;
  cell_op_e             op;
  logic                 shift_all;
  logic [ID_BITS-1:0]   r_id;
  logic [TIME_BITS-1:0] r_time;
  logic [STATUS_W-1:0]  status;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign fire     = (state_q == S_EXEC) && out_free;
  assign req_i.ready = (state_q == S_IDLE);

  // the cell row
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0]   lid, rid;
    logic [TIME_BITS-1:0] lt, rt;
    logic                 lle;

    if (g == 0) begin : g_first
      assign lid = id_q;
      assign lt  = wt_q;
      assign lle = 1'b1;
    end else begin : g_inner
      assign lid = cell_id[g-1];
      assign lt  = cell_time[g-1];
      assign lle = time_le[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign rid = cell_id[g];
      assign rt  = cell_time[g];
    end else begin : g_body
      assign rid = cell_id[g+1];
      assign rt  = cell_time[g+1];
    end

    assign id_hit[g]   = flags[g].id_hit;
    assign nid_hit[g]  = flags[g].nid_hit;
    assign time_le[g]  = flags[g].time_le;
    assign hit_upto[g] = |id_hit[g:0];

    assign ctl[g].op       = fire ? op : CELL_HOLD;
    assign ctl[g].valid    = CntW'(g) < count_q;
    assign ctl[g].shift_en = shift_all || hit_upto[g];
    assign ctl[g].left_le  = lle;

    wtq_cell #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[g]),
      .req_id_i     (id_q),
      .req_nid_i    (nid_q),
      .req_time_i   (wt_q),
      .left_id_i    (lid),
      .left_time_i  (lt),
      .right_id_i   (rid),
      .right_time_i (rt),
      .id_o         (cell_id[g]),
      .time_o       (cell_time[g]),
      .flags_o      (flags[g])
    );
  end

  assign any_hit     = |id_hit;
  assign any_nid_hit = |nid_hit;

  // wake time of the matching cell
  always_comb begin
    sel_time = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      sel_time = sel_time | (id_hit[i] ? cell_time[i] : '0);
    end
  end

  // decide the action's outcome from the row's compare flags
  always_comb begin
    op        = CELL_HOLD;
    shift_all = 1'b0;
    status    = ST_OK;
    r_id      = '0;
    count_d   = count_q;
    now_d     = now_q;
    r_time    = now_q;
    unique case (act_q)
      ACT_SCHEDULE: begin
        priority if (any_hit) begin
          status = ST_DUP;
        end else if (wt_q < now_q) begin
          status = ST_PAST;
        end else if (count_q == CntW'(QUEUE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          op      = CELL_INSERT;
          count_d = count_q + CntW'(1);
          r_id    = id_q;
        end
      end
      ACT_POP: begin
        if (count_q == '0 || cell_time[0] > now_q) begin
          status = ST_NOTDUE;
        end else begin
          op        = CELL_SHIFT;
          shift_all = 1'b1;
          count_d   = count_q - CntW'(1);
          r_id      = cell_id[0];
          r_time    = cell_time[0];
        end
      end
      ACT_REMOVE: begin
        if (!any_hit) begin
          status = ST_NOTFOUND;
        end else begin
          op      = CELL_SHIFT;
          count_d = count_q - CntW'(1);
          r_id    = id_q;
        end
      end
      ACT_REPLACE: begin
        priority if (!any_hit) begin
          status = ST_NOTFOUND;
        end else if (nid_q != id_q && any_nid_hit) begin
          status = ST_DUP;
        end else begin
          op     = CELL_RENAME;
          r_id   = nid_q;
          r_time = sel_time;
        end
      end
      ACT_TICK: begin
        now_d  = now_q + TIME_BITS'(1);
        r_time = now_d;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      now_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        count_q     <= count_d;
        now_q       <= now_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= req_i.action;
      id_q  <= ID_BITS'(req_i.entry_id);
      nid_q <= ID_BITS'(req_i.new_id);
      wt_q  <= TIME_BITS'(req_i.wake_at);
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_id_q     <= FIELD_ID_W'(r_id);
      rsp_time_q   <= FIELD_TIME_W'(r_time);
      rsp_status_q <= status;
      rsp_occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_id   = rsp_id_q;
  assign rsp_o.result_time = rsp_time_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.occupancy   = rsp_occ_q;

endmodule

### design/wtq_chk.sv
// port-level checker for the wake-time queue and its bind
`include "assert_macros.svh"

module wtq_chk import wtq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [FIELD_ID_W-1:0]   rsp_result_id_i,
  input logic [STATUS_W-1:0]     rsp_status_i,
  input logic [OCC_W-1:0]        rsp_occupancy_i
);

  localparam logic [OCC_W-1:0] FullOcc = OCC_W'(QUEUE_DEPTH);

  logic                           req_acc;
  logic                           rsp_stall;
  logic                           rsp_fail;
  logic                           rsp_full;
  logic [FIELD_ID_W+STATUS_W-1:0] rsp_pay;

  // handshake and payload views used by the checks
  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_fail  = rsp_valid_i && (rsp_status_i != ST_OK);
  assign rsp_full  = rsp_valid_i && (rsp_status_i == ST_FULL);
  assign rsp_pay   = {rsp_result_id_i, rsp_status_i};

  // one request at a time: no request taken right after another
  `WTQ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_acc, !req_ready_i)

  // a stalled response holds
  `WTQ_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_pay))

  // a failed action returns no id
  `WTQ_ASSERT_IMPLIES(a_fail_no_id, clk_i, rst_ni, rsp_fail, rsp_result_id_i == '0)

  // full is only reported with every slot in use
  `WTQ_ASSERT_IMPLIES(a_full_occ, clk_i, rst_ni, rsp_full, rsp_occupancy_i == FullOcc)

endmodule

bind sorted_wake_time_queue wtq_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_wtq_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_result_id_i (rsp_o.result_id),
  .rsp_status_i    (rsp_o.status),
  .rsp_occupancy_i (rsp_o.occupancy)
);

### dv/sorted_wake_time_queue_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the sorted wake-time queue: directed script, fill and random phases
module sorted_wake_time_queue_tb;
  import wtq_pkg::*;

  localparam int unsigned QUEUE_SLOTS    = 32;
  localparam int unsigned SCRIPT_LEN     = 24;
  localparam int unsigned SEGMENTS       = 20;
  localparam int unsigned SEGMENT_ITEMS  = 100;
  localparam int unsigned RSP_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // action codes the block ignores
  localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_C = 3'd7;

  // traffic mixes of the random segments
  localparam int unsigned MIX_BALANCED = 0;
  localparam int unsigned MIX_FILL     = 1;
  localparam int unsigned MIX_DRAIN    = 2;

  typedef struct packed {
    logic [FIELD_ID_W-1:0]   rid;
    logic [FIELD_TIME_W-1:0] rtime;
    logic [STATUS_W-1:0]     status;
    logic [OCC_W-1:0]        occ;
  } wake_result_t;

  typedef struct {
    logic [ACTION_W-1:0]     act;
    logic [FIELD_ID_W-1:0]   id;
    logic [FIELD_ID_W-1:0]   nid;
    logic [FIELD_TIME_W-1:0] wt;
    bit                      typed;
    wake_result_t            fixed;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  wtq_req_if req_bus ();
  wtq_rsp_if rsp_bus ();

  sorted_wake_time_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  // shadow copy of the queue contents and the time counter
  logic [FIELD_ID_W-1:0]   shadow_ids[$];
  logic [FIELD_TIME_W-1:0] shadow_wakes[$];
  logic [FIELD_TIME_W-1:0] shadow_now;

  wake_result_t awaited_responses[$];
  int unsigned  mismatch_count;
  int unsigned  idle_cycles;
  bit           tx_calm;
  bit           rx_calm;
  bit           rsp_hold_request;

  // directed opening: empty queue, extremes, every action and every error code but full
  script_row_t opening_script [SCRIPT_LEN] = '{
    '{ACT_POP,      16'h0000, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, ST_NOTDUE,   6'd0}},
    '{ACT_REMOVE,   16'h0005, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, ST_NOTFOUND, 6'd0}},
    '{ACT_REPLACE,  16'h0005, 16'h0006, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, ST_NOTFOUND, 6'd0}},
    '{ACT_SCHEDULE, 16'hffff, 16'h0000, 32'hffff_ffff, 1'b1, '{16'hffff, 32'h0, ST_OK,       6'd1}},
    '{ACT_SCHEDULE, 16'h0000, 16'hffff, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, ST_OK,       6'd2}},
    '{ACT_SCHEDULE, 16'hffff, 16'h0000, 32'h0000_0005, 1'b1, '{16'h0000, 32'h0, ST_DUP,      6'd2}},
    '{ACT_SCHEDULE, 16'h1234, 16'h0000, 32'h0000_0010, 1'b0, '0},
    '{ACT_SCHEDULE, 16'h1235, 16'h0000, 32'h0000_0010, 1'b0, '0},
    '{ACT_POP,      16'h0000, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, ST_OK,       6'd3}},
    '{ACT_POP,      16'h0000, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h0, ST_NOTDUE,   6'd3}},
    '{ACT_TICK,     16'h0000, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h1, ST_OK,       6'd3}},
    '{ACT_SCHEDULE, 16'h0007, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h1, ST_PAST,     6'd3}},
    '{ACT_SCHEDULE, 16'h1234, 16'h0000, 32'h0000_0000, 1'b1, '{16'h0000, 32'h1, ST_DUP,      6'd3}},
    '{ACT_REPLACE,  16'h1234, 16'h1235, 32'h0000_0000, 1'b1, '{16'h0000, 32'h1, ST_DUP,      6'd3}},
    '{ACT_REPLACE,  16'h1234, 16'h1234, 32'h0000_0000, 1'b1, '{16'h1234, 32'h10, ST_OK,      6'd3}},
    '{ACT_REPLACE,  16'h1234, 16'habcd, 32'h0000_0000, 1'b0, '0},
    '{ACT_SCHEDULE, 16'h5555, 16'h0000, 32'h8000_0001, 1'b0, '0},
    '{ACT_REMOVE,   16'h1235, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_RSVD_A,   16'hffff, 16'hffff, 32'hffff_ffff, 1'b0, '0},
    '{ACT_RSVD_B,   16'h00aa, 16'h0055, 32'h0000_0000, 1'b0, '0},
    '{ACT_RSVD_C,   16'h0000, 16'h0000, 32'h0000_0001, 1'b0, '0},
    '{ACT_SCHEDULE, 16'h00aa, 16'h0000, 32'h0000_0001, 1'b0, '0},
    '{ACT_POP,      16'h0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
    '{ACT_REMOVE,   16'hffff, 16'h0000, 32'h0000_0000, 1'b0, '0}
  };

  // clock and single reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // slot of an id in the shadow queue, -1 when absent
  function automatic int locate_id(input logic [FIELD_ID_W-1:0] id);
    foreach (shadow_ids[k]) begin
      if (shadow_ids[k] == id) return k;
    end
    return -1;
  endfunction

  // applies one action to the shadow queue and returns the response it should give
  function automatic wake_result_t predict_queue_action(
    input logic [ACTION_W-1:0]     act,
    input logic [FIELD_ID_W-1:0]   id,
    input logic [FIELD_ID_W-1:0]   nid,
    input logic [FIELD_TIME_W-1:0] wt
  );
    wake_result_t res;
    int           hit;
    int           pos;
    bit           time_kept;
    res       = '0;
    res.status = ST_OK;
    time_kept = 1'b0;
    hit       = locate_id(id);
    case (act)
      ACT_SCHEDULE: begin
        if (hit >= 0) begin
          res.status = ST_DUP;
        end else if (wt < shadow_now) begin
          res.status = ST_PAST;
        end else if (shadow_ids.size() >= QUEUE_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          // equal wake times keep their scheduling order
          pos = 0;
          while (pos < shadow_ids.size() && shadow_wakes[pos] <= wt) pos++;
          shadow_ids.insert(pos, id);
          shadow_wakes.insert(pos, wt);
          res.rid = id;
        end
      end
      ACT_POP: begin
        if (shadow_ids.size() == 0 || shadow_wakes[0] > shadow_now) begin
          res.status = ST_NOTDUE;
        end else begin
          res.rid   = shadow_ids.pop_front();
          res.rtime = shadow_wakes.pop_front();
          time_kept = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          shadow_ids.delete(hit);
          shadow_wakes.delete(hit);
          res.rid = id;
        end
      end
      ACT_REPLACE: begin
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else if (nid != id && locate_id(nid) >= 0) begin
          res.status = ST_DUP;
        end else begin
          shadow_ids[hit] = nid;
          res.rid   = nid;
          res.rtime = shadow_wakes[hit];
          time_kept = 1'b1;
        end
      end
      ACT_TICK: begin
        shadow_now = shadow_now + 1'b1;
      end
      default: begin
      end
    endcase
    if (!time_kept) res.rtime = shadow_now;
    res.occ = OCC_W'(shadow_ids.size());
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIELD_ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return FIELD_ID_W'($urandom_range(0, 63));
    if (r < 80 && shadow_ids.size() != 0)
      return shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
    return FIELD_ID_W'($urandom);
  endfunction

  function automatic logic [FIELD_ID_W-1:0] pick_queued_id();
    if (shadow_ids.size() != 0 && $urandom_range(0, 9) < 7)
      return shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
    return pick_id();
  endfunction

  function automatic logic [FIELD_TIME_W-1:0] pick_wake();
    int unsigned r;
    int unsigned back;
    r = $urandom_range(0, 99);
    if (r < 70) return shadow_now + $urandom_range(0, 24);
    if (r < 80 && shadow_now != 0) begin
      back = (shadow_now > 50) ? 50 : shadow_now;
      return shadow_now - $urandom_range(1, back);
    end
    if (r < 90) return $urandom;
    return shadow_now;
  endfunction

  // one random action, weighted by the segment's mix
  task automatic pick_random_action(
    input  int unsigned              mix,
    output logic [ACTION_W-1:0]     act,
    output logic [FIELD_ID_W-1:0]   id,
    output logic [FIELD_ID_W-1:0]   nid,
    output logic [FIELD_TIME_W-1:0] wt
  );
    int unsigned r;
    int unsigned lim_sched;
    int unsigned lim_pop;
    int unsigned lim_tick;
    int unsigned lim_remove;
    int unsigned lim_replace;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin lim_sched = 60; lim_pop = 68; lim_tick = 78; lim_remove = 86; end
      MIX_DRAIN: begin lim_sched = 15; lim_pop = 45; lim_tick = 75; lim_remove = 90; end
      default:   begin lim_sched = 35; lim_pop = 55; lim_tick = 75; lim_remove = 85; end
    endcase
    lim_replace = lim_remove + 10;
    id  = pick_id();
    nid = ($urandom_range(0, 99) < 15 && shadow_ids.size() != 0) ?
          shadow_ids[$urandom_range(0, shadow_ids.size() - 1)] : pick_id();
    wt  = pick_wake();
    if (r < lim_sched) begin
      act = ACT_SCHEDULE;
    end else if (r < lim_pop) begin
      act = ACT_POP;
    end else if (r < lim_tick) begin
      act = ACT_TICK;
    end else if (r < lim_remove) begin
      act = ACT_REMOVE;
      id  = pick_queued_id();
    end else if (r < lim_replace) begin
      act = ACT_REPLACE;
      id  = pick_queued_id();
    end else begin
      case ($urandom_range(0, 2))
        0:       act = ACT_RSVD_A;
        1:       act = ACT_RSVD_B;
        default: act = ACT_RSVD_C;
      endcase
    end
  endtask

  // offers one request, waits for acceptance, then records what should come back
  task automatic offer_action(
    input logic [ACTION_W-1:0]     act,
    input logic [FIELD_ID_W-1:0]   id,
    input logic [FIELD_ID_W-1:0]   nid,
    input logic [FIELD_TIME_W-1:0] wt,
    input bit                      typed,
    input wake_result_t            fixed
  );
    int unsigned  gap;
    wake_result_t predicted;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.action    <= act;
    req_bus.entry_id  <= id;
    req_bus.new_id    <= nid;
    req_bus.wake_at   <= wt;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predicted = predict_queue_action(act, id, nid, wt);
    awaited_responses.push_back(typed ? fixed : predicted);
  endtask

  // sender stops offering until every response is back
  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(
    input string       what,
    input logic [31:0] got,
    input logic [31:0] want
  );
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // request stimulus
  initial begin : stimulus
    logic [ACTION_W-1:0]     act;
    logic [FIELD_ID_W-1:0]   id;
    logic [FIELD_ID_W-1:0]   nid;
    logic [FIELD_TIME_W-1:0] wt;
    logic [FIELD_ID_W-1:0]   fill_id;
    int unsigned             mix;
    req_bus.valid     <= 1'b0;
    req_bus.action    <= ACT_TICK;
    req_bus.entry_id  <= '0;
    req_bus.new_id    <= '0;
    req_bus.wake_at   <= '0;
    shadow_now        = '0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    rsp_hold_request  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed script
    foreach (opening_script[k]) begin
      offer_action(opening_script[k].act, opening_script[k].id, opening_script[k].nid,
                   opening_script[k].wt, opening_script[k].typed, opening_script[k].fixed);
    end
    drain_responses();

    // fill to capacity behind a long response stall, then hit the full queue
    rsp_hold_request = 1'b1;
    fill_id = 16'h0100;
    while (shadow_ids.size() < QUEUE_SLOTS) begin
      offer_action(ACT_SCHEDULE, fill_id, '0, shadow_now + $urandom_range(0, 30), 1'b0, '0);
      fill_id++;
    end
    repeat (3) begin
      offer_action(ACT_SCHEDULE, fill_id, '0, shadow_now + $urandom_range(0, 30), 1'b0, '0);
      fill_id++;
    end
    offer_action(ACT_SCHEDULE, shadow_ids[QUEUE_SLOTS - 1], '0, shadow_now, 1'b0, '0);
    offer_action(ACT_TICK, '0, '0, '0, 1'b0, '0);
    offer_action(ACT_SCHEDULE, fill_id, '0, '0, 1'b0, '0);

    // random segments with changing mix and idling
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      mix     = (seg == 0) ? MIX_DRAIN : $urandom_range(MIX_BALANCED, MIX_DRAIN);
      if (seg == SEGMENTS / 2) drain_responses();
      repeat (SEGMENT_ITEMS) begin
        pick_random_action(mix, act, id, nid, wt);
        offer_action(act, id, nid, wt, 1'b0, '0);
      end
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sorted_wake_time_queue test passed");
    end else begin
      $display("sorted_wake_time_queue test failed");
    end
    $finish;
  end

  // response ready: random stalls, one long hold on request
  initial begin : rsp_ready_drive
    int unsigned stall;
    int unsigned run;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_request) begin
        rsp_bus.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
        rsp_hold_request = 1'b0;
      end else begin
        stall = pick_gap(rx_calm);
        if (stall != 0) begin
          rsp_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      rsp_bus.ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
    end
  end

  // response check against the oldest awaited result
  always @(posedge clk_i) begin : rsp_check
    wake_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("response with no request outstanding", 32'(rsp_bus.result_id), '0);
      end else begin
        want = awaited_responses.pop_front();
        if (rsp_bus.result_id !== want.rid)
          report_mismatch("result_id", 32'(rsp_bus.result_id), 32'(want.rid));
        if (rsp_bus.result_time !== want.rtime)
          report_mismatch("result_time", rsp_bus.result_time, want.rtime);
        if (rsp_bus.status !== want.status)
          report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
        if (rsp_bus.occupancy !== want.occ)
          report_mismatch("occupancy", 32'(rsp_bus.occupancy), 32'(want.occ));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin : stall_watch
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_wake_time_queue test failed");
        $finish;
      end
    end
  end

endmodule
